[sv/frt_pkg.sv]
// ----------------------------------------------------------------------------
// frt_pkg
// Shared types and constants for the fragment reassembly tracker.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int MAX_FRAGMENTS_DEF = 64;

  localparam int SEQ_W   = 16;
  localparam int IDX_W   = 8;
  localparam int PLEN_W  = 16;
  localparam int MAGIC_W = 8;
  localparam int HLEN_W  = 32;
  localparam int TIME_W  = 32;
  localparam int FRAME_W = 24;
  localparam int SIZE_W  = 16;
  localparam int SKIP_W  = 4;
  localparam int MS_W    = 23;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam logic [PLEN_W-1:0] HDR_BYTES       = 16'd4;
  localparam logic [PLEN_W-1:0] FRAME_HDR_BYTES = 16'd5;
  localparam logic [SKIP_W-1:0] SKIP_FIRST      = 4'd9;
  localparam logic [SKIP_W-1:0] SKIP_OTHER      = 4'd4;

  localparam logic [FRAME_W-1:0] FRAME_MAX_RST   = 24'd65536;
  localparam logic [SIZE_W-1:0]  FRAG_SIZE_RST   = 16'd1024;
  localparam logic [SIZE_W-1:0]  FIRST_DATA_RST  = 16'd1019;
  localparam logic [MAGIC_W-1:0] FRAME_MAGIC_RST = 8'd0;

  // us -> ms: drop 3 bits, then multiply by ceil(2^36 / 125)
  localparam int PRE_SHIFT = 3;
  localparam int DIV_W     = TIME_W - PRE_SHIFT;
  localparam int RECIP_W   = 30;
  localparam int RECIP_SH  = 36;
  localparam int PROD_W    = DIV_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_125 = 30'd549755814;

  typedef enum logic [1:0] {
    ST_DISCARD  = 2'd0,
    ST_PARTIAL  = 2'd1,
    ST_COMPLETE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_FRAME_MAX   = 2'd0,
    REG_FRAG_SIZE   = 2'd1,
    REG_FIRST_DATA  = 2'd2,
    REG_FRAME_MAGIC = 2'd3
  } reg_idx_t;

endpackage

[sv/frt_if.sv]
// ----------------------------------------------------------------------------
// frt_if
// Valid/ready channels for header summaries in and tracker results out.
// ----------------------------------------------------------------------------
interface frt_in_if import frt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SEQ_W-1:0]   seq_num;
  logic [IDX_W-1:0]   frag_index;
  logic [IDX_W-1:0]   frag_total;
  logic [PLEN_W-1:0]  pkt_length;
  logic [MAGIC_W-1:0] magic_byte;
  logic [HLEN_W-1:0]  header_frame_len;
  logic [TIME_W-1:0]  now_us;

  modport source (
    output valid, seq_num, frag_index, frag_total, pkt_length, magic_byte,
           header_frame_len, now_us,
    input  ready
  );
  modport sink (
    input  valid, seq_num, frag_index, frag_total, pkt_length, magic_byte,
           header_frame_len, now_us,
    output ready
  );
endinterface

interface frt_out_if import frt_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic               copy_valid;
  logic [FRAME_W-1:0] copy_offset;
  logic [SKIP_W-1:0]  copy_skip;
  logic [PLEN_W-1:0]  copy_length;
  logic [FRAME_W-1:0] done_frame_len;
  logic [MS_W-1:0]    transfer_ms;

  modport source (
    output valid, status, copy_valid, copy_offset, copy_skip, copy_length,
           done_frame_len, transfer_ms,
    input  ready
  );
  modport sink (
    input  valid, status, copy_valid, copy_offset, copy_skip, copy_length,
           done_frame_len, transfer_ms,
    output ready
  );
endinterface

[sv/fragment_reassembly_tracker.sv]
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker
// Each input beat passes the input reg, the update reg and the output reg
// to its result beat; one beat per cycle is sustained while downstream is
// ready. Ready follows downstream ready through the stages.
// Reset (synchronous, rst_n low) empties the pipe, clears tracking state and
// loads the register defaults.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker
  import frt_pkg::*;
#(
  parameter int MAX_FRAGMENTS = MAX_FRAGMENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  frt_in_if.sink                in_ch,
  frt_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int BMP_W = MAX_FRAGMENTS;
  localparam int TOT_W = $clog2(MAX_FRAGMENTS + 1);

  // configuration
  logic [FRAME_W-1:0] frame_max_r;
  logic [SIZE_W-1:0]  frag_size_r;
  logic [SIZE_W-1:0]  first_data_r;
  logic [MAGIC_W-1:0] frame_magic_r;
  reg_idx_t           reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_max_r   <= FRAME_MAX_RST;
      frag_size_r   <= FRAG_SIZE_RST;
      first_data_r  <= FIRST_DATA_RST;
      frame_magic_r <= FRAME_MAGIC_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRAME_MAX:   frame_max_r   <= pwdata[FRAME_W-1:0];
        REG_FRAG_SIZE:   frag_size_r   <= pwdata[SIZE_W-1:0];
        REG_FIRST_DATA:  first_data_r  <= pwdata[SIZE_W-1:0];
        REG_FRAME_MAGIC: frame_magic_r <= pwdata[MAGIC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_MAX:   prdata = CFG_DATA_W'(frame_max_r);
      REG_FRAG_SIZE:   prdata = CFG_DATA_W'(frag_size_r);
      REG_FIRST_DATA:  prdata = CFG_DATA_W'(first_data_r);
      REG_FRAME_MAGIC: prdata = CFG_DATA_W'(frame_magic_r);
      default:         prdata = '0;
    endcase
  end

  // pipeline flow
  logic s1_v_r, s2_v_r, out_v_r;
  logic s1_free, s2_free, s3_free, s1_move, s2_move;

  assign s3_free     = !out_v_r || out_ch.ready;
  assign s2_move     = s2_v_r && s3_free;
  assign s2_free     = !s2_v_r || s3_free;
  assign s1_move     = s1_v_r && s2_free;
  assign s1_free     = !s1_v_r || s2_free;
  assign in_ch.ready = s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_free) s1_v_r <= in_ch.valid;
      if (s2_free) s2_v_r <= s1_v_r;
      if (s3_free) out_v_r <= s2_v_r;
    end
  end

  // stage 1: input register, fragment offset worked out on entry
  logic [SEQ_W-1:0]   s1_seq_r;
  logic [IDX_W-1:0]   s1_fi_r;
  logic [IDX_W-1:0]   s1_total_r;
  logic [PLEN_W-1:0]  s1_plen_r;
  logic [MAGIC_W-1:0] s1_magic_r;
  logic [HLEN_W-1:0]  s1_hlen_r;
  logic [TIME_W-1:0]  s1_now_r;
  logic [FRAME_W-1:0] s1_off_r;
  logic [IDX_W-1:0]   in_fi_m1;
  logic [FRAME_W-1:0] in_off;

  assign in_fi_m1 = in_ch.frag_index - IDX_W'(1);
  assign in_off   = FRAME_W'(first_data_r) + FRAME_W'(in_fi_m1) * FRAME_W'(frag_size_r);

  always_ff @(posedge clk) begin
    if (s1_free && in_ch.valid) begin
      s1_seq_r   <= in_ch.seq_num;
      s1_fi_r    <= in_ch.frag_index;
      s1_total_r <= in_ch.frag_total;
      s1_plen_r  <= in_ch.pkt_length;
      s1_magic_r <= in_ch.magic_byte;
      s1_hlen_r  <= in_ch.header_frame_len;
      s1_now_r   <= in_ch.now_us;
      s1_off_r   <= in_off;
    end
  end

  // tracking state
  logic [SEQ_W-1:0]   cur_seq_r,   cur_seq_nxt;
  logic [TOT_W-1:0]   cur_total_r, cur_total_nxt;
  logic [BMP_W-1:0]   rx_bitmap_r, rx_bitmap_nxt;
  logic [FRAME_W-1:0] cur_flen_r,  cur_flen_nxt;
  logic [TIME_W-1:0]  start_us_r,  start_us_nxt;

  // stage 2 results
  status_t            s2_status_r,  s2_status_nxt;
  logic               s2_copy_r,    s2_copy_nxt;
  logic [FRAME_W-1:0] s2_offset_r,  s2_offset_nxt;
  logic [SKIP_W-1:0]  s2_skip_r,    s2_skip_nxt;
  logic [PLEN_W-1:0]  s2_length_r,  s2_length_nxt;
  logic [FRAME_W-1:0] s2_flen_r,    s2_flen_nxt;
  logic [TIME_W-1:0]  s2_elapsed_r, s2_elapsed_nxt;

  logic               hdr_bad, restart, bad0, oversize, oob;
  logic [PLEN_W-1:0]  dlen, len;
  logic [FRAME_W-1:0] off;
  logic [SKIP_W-1:0]  skip;
  logic [BMP_W-1:0]   full_mask, base_bmp;
  logic [TIME_W-1:0]  base_start;

  always_comb begin
    cur_seq_nxt    = cur_seq_r;
    cur_total_nxt  = cur_total_r;
    rx_bitmap_nxt  = rx_bitmap_r;
    cur_flen_nxt   = cur_flen_r;
    start_us_nxt   = start_us_r;
    s2_status_nxt  = ST_DISCARD;
    s2_copy_nxt    = 1'b0;
    s2_offset_nxt  = '0;
    s2_skip_nxt    = '0;
    s2_length_nxt  = '0;
    s2_flen_nxt    = '0;
    s2_elapsed_nxt = '0;

    for (int i = 0; i < BMP_W; i++) begin
      full_mask[i] = (IDX_W'(i) < s1_total_r);
    end

    dlen    = s1_plen_r - HDR_BYTES;
    hdr_bad = (s1_plen_r < HDR_BYTES) || (s1_total_r == '0) ||
              (s1_fi_r >= s1_total_r) || (s1_total_r > IDX_W'(MAX_FRAGMENTS));
    restart = (cur_total_r == '0) || (s1_seq_r != cur_seq_r) ||
              (s1_total_r != IDX_W'(cur_total_r));

    base_bmp   = restart ? '0 : rx_bitmap_r;
    base_start = restart ? s1_now_r : start_us_r;
    bad0       = 1'b0;
    oversize   = 1'b0;

    if (s1_fi_r == '0) begin
      bad0     = (dlen < FRAME_HDR_BYTES) || (s1_magic_r != frame_magic_r);
      oversize = s1_hlen_r > HLEN_W'(frame_max_r);
      off      = '0;
      len      = dlen - FRAME_HDR_BYTES;
      skip     = SKIP_FIRST;
    end else begin
      off      = s1_off_r;
      len      = dlen;
      skip     = SKIP_OTHER;
    end
    oob = ({1'b0, off} + (FRAME_W + 1)'(len)) > {1'b0, frame_max_r};

    if (!hdr_bad) begin
      if (restart) begin
        cur_seq_nxt   = s1_seq_r;
        cur_total_nxt = s1_total_r[TOT_W-1:0];
        rx_bitmap_nxt = '0;
        cur_flen_nxt  = '0;
        start_us_nxt  = s1_now_r;
      end
      if (s1_fi_r == '0 && !bad0) begin
        if (oversize) cur_total_nxt = '0;
        else cur_flen_nxt = s1_hlen_r[FRAME_W-1:0];
      end
      if (!bad0 && !oversize && !oob) begin
        rx_bitmap_nxt = base_bmp | (BMP_W'(1) << s1_fi_r);
        s2_copy_nxt   = 1'b1;
        s2_offset_nxt = off;
        s2_skip_nxt   = skip;
        s2_length_nxt = len;
        if (rx_bitmap_nxt == full_mask) begin
          s2_status_nxt  = ST_COMPLETE;
          s2_flen_nxt    = cur_flen_nxt;
          s2_elapsed_nxt = s1_now_r - base_start;
          cur_total_nxt  = '0;
        end else begin
          s2_status_nxt  = ST_PARTIAL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_seq_r   <= '0;
      cur_total_r <= '0;
      rx_bitmap_r <= '0;
      cur_flen_r  <= '0;
      start_us_r  <= '0;
    end else if (s1_move) begin
      cur_seq_r   <= cur_seq_nxt;
      cur_total_r <= cur_total_nxt;
      rx_bitmap_r <= rx_bitmap_nxt;
      cur_flen_r  <= cur_flen_nxt;
      start_us_r  <= start_us_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_status_r  <= s2_status_nxt;
      s2_copy_r    <= s2_copy_nxt;
      s2_offset_r  <= s2_offset_nxt;
      s2_skip_r    <= s2_skip_nxt;
      s2_length_r  <= s2_length_nxt;
      s2_flen_r    <= s2_flen_nxt;
      s2_elapsed_r <= s2_elapsed_nxt;
    end
  end

  // stage 3: us to ms by reciprocal multiply, output register
  logic [PROD_W-1:0]  ms_prod;
  status_t            out_status_r;
  logic               out_copy_r;
  logic [FRAME_W-1:0] out_offset_r;
  logic [SKIP_W-1:0]  out_skip_r;
  logic [PLEN_W-1:0]  out_length_r;
  logic [FRAME_W-1:0] out_flen_r;
  logic [MS_W-1:0]    out_ms_r;

  assign ms_prod = PROD_W'(s2_elapsed_r[TIME_W-1:PRE_SHIFT]) * PROD_W'(RECIP_125);

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_status_r <= s2_status_r;
      out_copy_r   <= s2_copy_r;
      out_offset_r <= s2_offset_r;
      out_skip_r   <= s2_skip_r;
      out_length_r <= s2_length_r;
      out_flen_r   <= s2_flen_r;
      out_ms_r     <= ms_prod[RECIP_SH +: MS_W];
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.copy_valid     = out_copy_r;
  assign out_ch.copy_offset    = out_offset_r;
  assign out_ch.copy_skip      = out_skip_r;
  assign out_ch.copy_length    = out_length_r;
  assign out_ch.done_frame_len = out_flen_r;
  assign out_ch.transfer_ms    = out_ms_r;

`ifndef NO_ASSERTIONS
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v_r && s2_v_r && out_v_r))
    else $error("input stalled with a bubble in the pipe");

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_total_r <= TOT_W'(MAX_FRAGMENTS))
    else $error("tracked fragment count out of range");

  a_complete_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && s2_status_nxt == ST_COMPLETE) |=> (cur_total_r == '0))
    else $error("tracker not idle after frame complete");

  a_partial_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_status_r != ST_COMPLETE) |-> (out_ms_r == '0 && out_flen_r == '0))
    else $error("completion fields set on non-complete beat");

  a_discard_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_status_r == ST_DISCARD) |->
      (!out_copy_r && out_length_r == '0 && out_offset_r == '0 && out_skip_r == '0))
    else $error("copy command on discarded beat");
`endif

endmodule
